// ===== rtl/core/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Types and constants shared by the thermostat command controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_AUTO   = 2'd1,
		MODE_MANUAL = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		RPT_NONE     = 2'd0,
		RPT_SETPOINT = 2'd1,
		RPT_TARGET   = 2'd2
	} report_kind_t;

	typedef enum logic [0:0] {
		CFG_HOT  = 1'b0,
		CFG_WARM = 1'b1
	} cfg_idx_t;

	localparam logic [9:0] HOT_RESET  = 10'd614;
	localparam logic [9:0] WARM_RESET = 10'd410;

	localparam logic [4:0] SP_MIN = 5'd18;
	localparam logic [4:0] SP_MID = 5'd22;
	localparam logic [4:0] SP_MAX = 5'd26;

	// indicator levels: cool high, cool low, heat, fan
	localparam logic [3:0] LV_NONE      = 4'b0000;
	localparam logic [3:0] LV_COOL_HARD = 4'b1001;
	localparam logic [3:0] LV_COOL_SOFT = 4'b0100;
	localparam logic [3:0] LV_HEAT      = 4'b0010;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_M  = 8'h4D;
	localparam logic [7:0] CH_UP_O  = 8'h4F;
	localparam logic [7:0] CH_LO_F  = 8'h66;

	// command decode handed from the character store to the control unit
	typedef struct packed {
		logic term;
		logic is_off;
		logic is_mplus;
		logic is_mminus;
		logic is_auto;
	} cmd_match_t;

	typedef struct packed {
		logic [3:0]   levels;
		logic         beep;
		report_kind_t report_kind;
		logic [4:0]   report_value;
		mode_t        mode_now;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcc_in_if.sv =====
// ----------------------------------------------------------------------------
// tcc_in_if
// Input channel: serial byte or temperature sample beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;
	logic [9:0] sample;

	modport source (output valid, cmd, rx_byte, sample, input ready);
	modport sink (input valid, cmd, rx_byte, sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tcc_out_if.sv =====
// ----------------------------------------------------------------------------
// tcc_out_if
// Result channel: indicator levels, beep, report and mode beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_out_if;
	logic       valid;
	logic       ready;
	logic       cool_high_led;
	logic       cool_low_led;
	logic       heat_led;
	logic       fan_on;
	logic       beep;
	logic [1:0] report_kind;
	logic [4:0] report_value;
	logic [1:0] mode_now;

	modport source (output valid, cool_high_led, cool_low_led, heat_led, fan_on, beep,
		report_kind, report_value, mode_now, input ready);
	modport sink (input valid, cool_high_led, cool_low_led, heat_led, fan_on, beep,
		report_kind, report_value, mode_now, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tcc_cmd_buf.sv =====
// ----------------------------------------------------------------------------
// tcc_cmd_buf
// Command character store with fill count and keyword match.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_cmd_buf #(
	parameter int CMD_CHARS = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_vld,
	input  wire logic [7:0]          rx_byte,
	output tcc_pkg::cmd_match_t      match
);
	import tcc_pkg::*;

	localparam int CW = $clog2(CMD_CHARS + 1);
	localparam int IW = $clog2(CMD_CHARS);

	logic [7:0]    chars_q [CMD_CHARS];
	logic [CW-1:0] count_q;
	logic          collect;

	assign collect = byte_vld && (rx_byte != CH_CR) && (rx_byte != CH_LF)
		&& (count_q < CW'(CMD_CHARS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (byte_vld) begin
			count_q <= collect ? count_q + CW'(1) : '0;
		end
	end

	// no reset: only entries below the count are read
	always_ff @(posedge clk) begin
		if (collect) begin
			chars_q[count_q[IW-1:0]] <= rx_byte;
		end
	end

	// match against the held text, before this beat updates it
	always_comb begin
		match.term      = byte_vld && !collect;
		match.is_off    = (count_q == CW'(3)) && (chars_q[0] == CH_UP_O)
			&& (chars_q[1] == CH_LO_F) && (chars_q[2] == CH_LO_F);
		match.is_mplus  = (count_q == CW'(2)) && (chars_q[0] == CH_UP_M)
			&& (chars_q[1] == CH_PLUS);
		match.is_mminus = (count_q == CW'(2)) && (chars_q[0] == CH_UP_M)
			&& (chars_q[1] == CH_MINUS);
		match.is_auto   = (count_q == CW'(1)) && (chars_q[0] == CH_UP_A);
	end

endmodule

`default_nettype wire

// ===== rtl/core/tcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcc_ctrl
// Mode, setpoint and indicator state; builds the result of each beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire logic                cmd,
	input  wire logic [9:0]          sample,
	input  wire tcc_pkg::cmd_match_t match,
	input  wire logic [9:0]          hot_th,
	input  wire logic [9:0]          warm_th,
	output tcc_pkg::result_t         res
);
	import tcc_pkg::*;

	mode_t      mode_q, mode_d;
	logic [4:0] sp_q, sp_d;
	logic [3:0] lv_q, lv_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
			sp_q   <= SP_MIN;
			lv_q   <= LV_NONE;
		end else if (fire) begin
			mode_q <= mode_d;
			sp_q   <= sp_d;
			lv_q   <= lv_d;
		end
	end

	always_comb begin
		mode_d           = mode_q;
		sp_d             = sp_q;
		lv_d             = lv_q;
		res.beep         = 1'b0;
		res.report_kind  = RPT_NONE;
		res.report_value = '0;
		if (!cmd) begin
			if (match.term) begin
				if (match.is_off) begin
					lv_d     = LV_NONE;
					mode_d   = MODE_OFF;
					res.beep = 1'b1;
				end else if (match.is_mplus) begin
					mode_d   = MODE_MANUAL;
					res.beep = 1'b1;
					if (sp_q >= SP_MIN && sp_q < SP_MAX) begin
						sp_d             = sp_q + 5'd1;
						res.report_kind  = RPT_SETPOINT;
						res.report_value = sp_d;
					end
				end else if (match.is_mminus) begin
					mode_d   = MODE_MANUAL;
					res.beep = 1'b1;
					if (sp_q > SP_MIN && sp_q <= SP_MAX) begin
						sp_d             = sp_q - 5'd1;
						res.report_kind  = RPT_SETPOINT;
						res.report_value = sp_d;
					end
				end else if (match.is_auto) begin
					mode_d   = MODE_AUTO;
					res.beep = 1'b1;
				end
			end
		end else begin
			case (mode_q)
				MODE_AUTO: begin
					res.report_kind = RPT_TARGET;
					if (sample >= hot_th) begin
						lv_d             = LV_COOL_HARD;
						res.report_value = SP_MIN;
					end else if (sample >= warm_th) begin
						lv_d             = LV_COOL_SOFT;
						res.report_value = SP_MID;
					end else begin
						lv_d             = LV_HEAT;
						res.report_value = SP_MAX;
					end
				end
				MODE_MANUAL: begin
					if (sp_q < SP_MID) begin
						lv_d = LV_COOL_HARD;
					end else if (sp_q < SP_MAX) begin
						lv_d = LV_COOL_SOFT;
					end else begin
						lv_d = LV_HEAT;
					end
				end
				default: begin
					lv_d = lv_q;
				end
			endcase
		end
		res.levels   = lv_d;
		res.mode_now = mode_d;
	end

endmodule

`default_nettype wire

// ===== rtl/core/thermostat_command_controller.sv =====
// ----------------------------------------------------------------------------
// thermostat_command_controller
// Serial command decoder and temperature-driven indicator controller.
// ----------------------------------------------------------------------------
// Takes one beat per clock on the items channel, unless results stall: a
// received byte (cmd 0) or a raw 10-bit sample (cmd 1). Each beat yields
// exactly one result beat, held first in the input register and then in
// the result register. Throughput is one beat per cycle, limited only by
// backpressure on results. Bytes other than CR/LF are held until
// CMD_CHARS are stored; the next CR, LF or overflowing byte ends the
// command, which is matched against Off, M+, M- and A. Threshold registers
// are written through cfg_we/cfg_idx/cfg_wdata (0 hot, 1 warm) and must
// only change while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module thermostat_command_controller #(
	parameter int CMD_CHARS = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_idx,
	input  wire logic [9:0] cfg_wdata,
	tcc_in_if.sink          items,
	tcc_out_if.source       results
);
	import tcc_pkg::*;

	// configuration registers
	logic [9:0] hot_q, warm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hot_q  <= HOT_RESET;
			warm_q <= WARM_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_HOT:  hot_q  <= cfg_wdata;
				CFG_WARM: warm_q <= cfg_wdata;
				default:  hot_q  <= hot_q;
			endcase
		end
	end

	// input register stage
	logic       vld_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic [9:0] sample_s1;
	logic       advance;
	logic       fire;
	logic       take;

	// result register
	logic    res_vld_q;
	result_t res_q;
	result_t res_d;

	// stage 1 moves on whenever the result slot is empty or being drained
	assign advance     = !res_vld_q || results.ready;
	assign fire        = vld_s1 && advance;
	assign items.ready = !vld_s1 || advance;
	assign take        = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (items.ready) begin
			vld_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1    <= items.cmd;
			byte_s1   <= items.rx_byte;
			sample_s1 <= items.sample;
		end
	end

	cmd_match_t match;

	tcc_cmd_buf #(
		.CMD_CHARS (CMD_CHARS)
	) u_cmd_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_vld (fire && !cmd_s1),
		.rx_byte  (byte_s1),
		.match    (match)
	);

	tcc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.cmd     (cmd_s1),
		.sample  (sample_s1),
		.match   (match),
		.hot_th  (hot_q),
		.warm_th (warm_q),
		.res     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign results.valid         = res_vld_q;
	assign results.cool_high_led = res_q.levels[3];
	assign results.cool_low_led  = res_q.levels[2];
	assign results.heat_led      = res_q.levels[1];
	assign results.fan_on        = res_q.levels[0];
	assign results.beep          = res_q.beep;
	assign results.report_kind   = res_q.report_kind;
	assign results.report_value  = res_q.report_value;
	assign results.mode_now      = res_q.mode_now;

endmodule

`default_nettype wire
